// ===== sv/bcpa_pkg.sv =====
// Shared constants, codes and control types of the bitmap page allocator.
package bcpa_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_COUNT = 1024;

    localparam int ADDR_W     = 32;
    localparam int BASE_W     = 20;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Bitmap memory geometry: one bit per page, WORD_BITS pages per row
    localparam int WORD_BITS  = 16;
    localparam int WORD_SHIFT = $clog2(WORD_BITS);
    localparam int WORDS      = PAGE_COUNT / WORD_BITS;
    localparam int WIDX_W     = $clog2(WORDS);

    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int NEED_W     = ADDR_W - PAGE_SHIFT + 1;
    localparam int EXT_W      = NEED_W + 2;
    localparam int RUN_W      = $clog2(PAGE_COUNT + WORD_BITS) + 1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_ZERO  = 2'd1,
        STATUS_NOFIT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_FOUND,
        ST_MARK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic    load;
        logic    setup;
        logic    scan_step;
        logic    found_init;
        logic    mark_step;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic zero_size;
        logic too_big;
        logic range_empty;
        logic hit;
        logic scan_fail;
        logic sweep_done;
    } stat_t;

endpackage

// ===== sv/bcpa_ctrl.sv =====
// Sequencing state machine of the bitmap page allocator.
module bcpa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output bcpa_pkg::cmd_t  cmd,
    input  bcpa_pkg::stat_t stat
);

    bcpa_pkg::state_t  state_reg, state_next;
    bcpa_pkg::status_t code_reg, code_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bcpa_pkg::ST_IDLE;
            code_reg    <= bcpa_pkg::STATUS_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        code_next      = code_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.out_status = code_reg;
        case (state_reg)
            bcpa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = bcpa_pkg::ST_SETUP;
                end
            end
            bcpa_pkg::ST_SETUP: begin
                cmd.setup = 1'b1;
                code_next = bcpa_pkg::STATUS_DONE;
                if (stat.is_free) begin
                    state_next = stat.range_empty ? bcpa_pkg::ST_RESP : bcpa_pkg::ST_MARK;
                end else if (stat.zero_size) begin
                    code_next  = bcpa_pkg::STATUS_ZERO;
                    state_next = bcpa_pkg::ST_RESP;
                end else if (stat.too_big) begin
                    code_next  = bcpa_pkg::STATUS_NOFIT;
                    state_next = bcpa_pkg::ST_RESP;
                end else begin
                    state_next = bcpa_pkg::ST_SCAN;
                end
            end
            bcpa_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.hit) begin
                    state_next = bcpa_pkg::ST_FOUND;
                end else if (stat.scan_fail) begin
                    code_next  = bcpa_pkg::STATUS_NOFIT;
                    state_next = bcpa_pkg::ST_RESP;
                end
            end
            bcpa_pkg::ST_FOUND: begin
                cmd.found_init = 1'b1;
                state_next     = bcpa_pkg::ST_MARK;
            end
            bcpa_pkg::ST_MARK: begin
                cmd.mark_step = 1'b1;
                if (stat.sweep_done) begin
                    state_next = bcpa_pkg::ST_RESP;
                end
            end
            bcpa_pkg::ST_RESP: begin
                // wait for the output word slot to drain
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = bcpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bcpa_pkg::ST_IDLE;
            end
        endcase
        m_valid_next = (m_valid_reg && !m_ready) || cmd.out_load;
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== sv/bcpa_dpath.sv =====
// Datapath of the bitmap page allocator: bitmap memory, run scan and range update.
module bcpa_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcpa_pkg::BASE_W-1:0]   cfg_base_page,
    input  logic                          s_mode,
    input  logic [bcpa_pkg::ADDR_W-1:0]   s_request_bytes,
    input  logic [bcpa_pkg::ADDR_W-1:0]   s_address,
    output logic [bcpa_pkg::ADDR_W-1:0]   m_result_address,
    output logic [1:0]                    m_status,
    input  bcpa_pkg::cmd_t                cmd,
    output bcpa_pkg::stat_t               stat
);

    localparam int ADDR_W     = bcpa_pkg::ADDR_W;
    localparam int BASE_W     = bcpa_pkg::BASE_W;
    localparam int PAGE_SHIFT = bcpa_pkg::PAGE_SHIFT;
    localparam int WORD_BITS  = bcpa_pkg::WORD_BITS;
    localparam int WORD_SHIFT = bcpa_pkg::WORD_SHIFT;
    localparam int WORDS      = bcpa_pkg::WORDS;
    localparam int WIDX_W     = bcpa_pkg::WIDX_W;
    localparam int IDX_W      = bcpa_pkg::IDX_W;
    localparam int CNT_W      = bcpa_pkg::CNT_W;
    localparam int NEED_W     = bcpa_pkg::NEED_W;
    localparam int EXT_W      = bcpa_pkg::EXT_W;
    localparam int RUN_W      = bcpa_pkg::RUN_W;

    // page offset of a clamped into [0, PAGE_COUNT] relative to b
    function automatic logic [CNT_W-1:0] clamp_rel(input logic [EXT_W-1:0] a,
                                                   input logic [EXT_W-1:0] b);
        logic [EXT_W-1:0] diff;
        diff = a - b;
        if (a <= b) begin
            clamp_rel = '0;
        end else if (diff > EXT_W'(bcpa_pkg::PAGE_COUNT)) begin
            clamp_rel = CNT_W'(bcpa_pkg::PAGE_COUNT);
        end else begin
            clamp_rel = diff[CNT_W-1:0];
        end
    endfunction

    // registers
    logic [BASE_W-1:0]     base_reg, base_next;
    logic                  mode_reg, mode_next;
    logic [ADDR_W-1:0]     bytes_reg, bytes_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [WIDX_W:0]       rd_ptr_reg, rd_ptr_next;
    logic [WIDX_W-1:0]     rd_end_reg, rd_end_next;
    logic                  pend_reg, pend_next;
    logic [WIDX_W-1:0]     proc_reg, proc_next;
    logic [RUN_W-1:0]      carry_reg, carry_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    bcpa_pkg::status_t     out_status_reg, out_status_next;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  row_ok_rd_reg;
    logic                  row_ok_reg [WORDS];
    logic [WORD_BITS-1:0]  bitmap_mem [WORDS];

    // combinational
    logic [NEED_W-1:0]     need_c;
    logic [EXT_W-1:0]      first_e, end_e, base_e;
    logic [CNT_W-1:0]      lo_c, hi_c, last_c;
    logic [CNT_W-1:0]      start_c, fhi_c, fend_c;
    logic [BASE_W:0]       abs_page_c;
    logic [ADDR_W-1:0]     res_c;
    logic [WORD_BITS-1:0]  word_c, mask_c, wdata_c;
    logic [RUN_W-1:0]      run_at [WORD_BITS];
    logic [WORD_BITS-1:0]  hit_vec;
    logic [WORD_SHIFT-1:0] hit_pos;
    logic                  any_hit;
    logic                  rd_issue;
    logic                  we;

    assign cfg_ready = 1'b1;

    // request decode
    assign need_c  = NEED_W'(bytes_reg[ADDR_W-1:PAGE_SHIFT])
                   + NEED_W'(|bytes_reg[PAGE_SHIFT-1:0]);
    assign first_e = EXT_W'(addr_reg[ADDR_W-1:PAGE_SHIFT]);
    assign end_e   = first_e + EXT_W'(need_c);
    assign base_e  = EXT_W'(base_reg);
    assign lo_c    = clamp_rel(first_e, base_e);
    assign hi_c    = clamp_rel(end_e, base_e);
    assign last_c  = hi_c - CNT_W'(1);

    // placement of a found run
    assign start_c    = CNT_W'(hit_idx_reg) + CNT_W'(1) - CNT_W'(need_c);
    assign fhi_c      = start_c + CNT_W'(need_c);
    assign fend_c     = fhi_c - CNT_W'(1);
    assign abs_page_c = (BASE_W+1)'(base_reg) + (BASE_W+1)'(start_c);
    assign res_c      = ADDR_W'(abs_page_c) << PAGE_SHIFT;

    // rows never written read as all free
    assign word_c   = row_ok_rd_reg ? rd_data_reg : '0;
    assign rd_issue = (cmd.scan_step || cmd.mark_step)
                   && (rd_ptr_reg <= {1'b0, rd_end_reg});
    assign we       = cmd.mark_step && pend_reg;

    // free-run length ending at each bit, carried in from the rows below
    always_comb begin
        logic [WORD_SHIFT:0] last_used;
        logic [WORD_SHIFT:0] flen;
        for (int p = 0; p < WORD_BITS; p++) begin
            last_used = '0;
            for (int q = 0; q < WORD_BITS; q++) begin
                if (q <= p && word_c[q]) begin
                    last_used = (WORD_SHIFT+1)'(q + 1);
                end
            end
            flen = (WORD_SHIFT+1)'(p + 1) - last_used;
            if (last_used == '0) begin
                run_at[p] = carry_reg + RUN_W'(p + 1);
            end else begin
                run_at[p] = RUN_W'(flen);
            end
            hit_vec[p] = NEED_W'(run_at[p]) >= need_c;
        end
        any_hit = |hit_vec;
        hit_pos = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (hit_vec[p]) begin
                hit_pos = WORD_SHIFT'(p);
            end
        end
    end

    // page mask of the current row against [lo, hi)
    always_comb begin
        logic [IDX_W-1:0] g;
        for (int p = 0; p < WORD_BITS; p++) begin
            g         = {proc_reg, WORD_SHIFT'(p)};
            mask_c[p] = (CNT_W'(g) >= lo_reg) && (CNT_W'(g) < hi_reg);
        end
        if (mode_reg == bcpa_pkg::MODE_ALLOC) begin
            wdata_c = word_c | mask_c;
        end else begin
            wdata_c = word_c & ~mask_c;
        end
    end

    always_comb begin
        stat.is_free     = (mode_reg == bcpa_pkg::MODE_FREE);
        stat.zero_size   = (bytes_reg == '0);
        stat.too_big     = (need_c > NEED_W'(bcpa_pkg::PAGE_COUNT));
        stat.range_empty = (lo_c >= hi_c);
        stat.hit         = pend_reg && any_hit;
        stat.scan_fail   = pend_reg && !any_hit && (proc_reg == rd_end_reg);
        stat.sweep_done  = pend_reg && (proc_reg == rd_end_reg);
    end

    always_comb begin
        base_next       = base_reg;
        mode_next       = mode_reg;
        bytes_next      = bytes_reg;
        addr_next       = addr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_end_next     = rd_end_reg;
        pend_next       = pend_reg;
        proc_next       = proc_reg;
        carry_next      = carry_reg;
        hit_idx_next    = hit_idx_reg;
        res_addr_next   = res_addr_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        if (cfg_valid) begin
            base_next = cfg_base_page;
        end
        if (cmd.load) begin
            mode_next  = s_mode;
            bytes_next = s_request_bytes;
            addr_next  = s_address;
        end
        if (cmd.setup) begin
            pend_next     = 1'b0;
            res_addr_next = '0;
            carry_next    = '0;
            if (mode_reg == bcpa_pkg::MODE_FREE) begin
                lo_next     = lo_c;
                hi_next     = hi_c;
                rd_ptr_next = lo_c[CNT_W-1:WORD_SHIFT];
                rd_end_next = last_c[IDX_W-1:WORD_SHIFT];
            end else begin
                rd_ptr_next = '0;
                rd_end_next = WIDX_W'(WORDS - 1);
            end
        end
        if (cmd.scan_step || cmd.mark_step) begin
            pend_next = rd_issue;
            if (rd_issue) begin
                rd_ptr_next = rd_ptr_reg + (WIDX_W+1)'(1);
                proc_next   = rd_ptr_reg[WIDX_W-1:0];
            end
        end
        if (cmd.scan_step && pend_reg) begin
            carry_next = run_at[WORD_BITS-1];
            if (any_hit) begin
                hit_idx_next = {proc_reg, hit_pos};
            end
        end
        if (cmd.found_init) begin
            pend_next     = 1'b0;
            lo_next       = start_c;
            hi_next       = fhi_c;
            rd_ptr_next   = start_c[CNT_W-1:WORD_SHIFT];
            rd_end_next   = fend_c[IDX_W-1:WORD_SHIFT];
            res_addr_next = res_c;
        end
        if (cmd.out_load) begin
            out_addr_next   = res_addr_reg;
            out_status_next = cmd.out_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            base_reg <= base_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        bytes_reg      <= bytes_next;
        addr_reg       <= addr_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        rd_ptr_reg     <= rd_ptr_next;
        rd_end_reg     <= rd_end_next;
        proc_reg       <= proc_next;
        carry_reg      <= carry_next;
        hit_idx_reg    <= hit_idx_next;
        res_addr_reg   <= res_addr_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // per-row written flags stand in for clearing the map at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WORDS; k++) begin
                row_ok_reg[k] <= 1'b0;
            end
        end else if (we) begin
            row_ok_reg[proc_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_data_reg   <= bitmap_mem[rd_ptr_reg[WIDX_W-1:0]];
            row_ok_rd_reg <= row_ok_reg[rd_ptr_reg[WIDX_W-1:0]];
        end
        if (we) begin
            bitmap_mem[proc_reg] <= wdata_c;
        end
    end

    assign m_result_address = out_addr_reg;
    assign m_status         = out_status_reg;

    a_found_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.found_init |=> (hi_reg <= CNT_W'(bcpa_pkg::PAGE_COUNT)) && (lo_reg < hi_reg))
        else $error("found run does not fit in the pool");

    a_mark_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && mode_reg == bcpa_pkg::MODE_ALLOC) |-> ((word_c & mask_c) == '0))
        else $error("allocation marks a page already in use");

    a_carry_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && pend_reg && !any_hit) |=> (NEED_W'(carry_reg) < need_c))
        else $error("carried run reached the request without a hit");

    a_free_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.setup && stat.is_free && !stat.range_empty)
        |=> (rd_ptr_reg <= {1'b0, rd_end_reg}))
        else $error("free sweep starts past its last row");

endmodule

// ===== sv/bitmap_contiguous_page_allocator.sv =====
// Bitmap first-fit page allocator: top level joining controller and datapath.
// One item at a time. The occupancy map is a memory of 64 rows of 16 page bits with one
// read and one write port. An allocate is decoded, then scans rows from row 0 until the
// run is found or the last row gives no fit, places the run, rewrites the rows the run
// covers and posts the result word. A free is decoded, clears the rows covered and posts,
// or posts straight after decode when the region covers no pool page. Zero-size and
// oversize allocates answer after decode. A new word is taken while the last result word
// still waits on m_ready. Reset leaves the map all free at once, with no clearing pass.
// base_page may be written only while the block is idle.
module bitmap_contiguous_page_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bcpa_pkg::BASE_W-1:0] cfg_base_page,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [bcpa_pkg::ADDR_W-1:0] s_request_bytes,
    input  logic [bcpa_pkg::ADDR_W-1:0] s_address,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bcpa_pkg::ADDR_W-1:0] m_result_address,
    output logic [1:0]                  m_status
);

    bcpa_pkg::cmd_t  cmd;
    bcpa_pkg::stat_t stat;

    bcpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    bcpa_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_base_page    (cfg_base_page),
        .s_mode           (s_mode),
        .s_request_bytes  (s_request_bytes),
        .s_address        (s_address),
        .m_result_address (m_result_address),
        .m_status         (m_status),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

// ===== tb/bitmap_contiguous_page_allocator_test.sv =====
// Self-checking bench for the bitmap first-fit page allocator: map model, random traffic.
module bitmap_contiguous_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bcpa_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int PHASE_ITEMS  = 110;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 22;
    localparam int REPORT_CAP   = 30;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        status_t           status;
    } page_answer_t;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] bytes;
    } held_region_t;

    // Occupancy map and pool base, plus the answers still owed by the block
    class page_occupancy_board;
        bit [PAGE_COUNT-1:0] page_used;
        logic [BASE_W-1:0]   base_page;
        page_answer_t        due_answers[$];
        int                  errors;
        int                  checked;

        function new();
            page_used = '0;
            base_page = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function page_answer_t predict_request(logic mode, logic [ADDR_W-1:0] bytes,
                                               logic [ADDR_W-1:0] addr);
            page_answer_t ans;
            logic [63:0]  need;
            logic [63:0]  first_page;
            logic [63:0]  stop_page;
            logic [63:0]  abs_page;
            logic [63:0]  byte_addr;
            int           run;
            int           run_start;
            ans.address = '0;
            ans.status  = STATUS_DONE;
            need        = (64'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            run         = 0;
            run_start   = 0;
            if (mode == MODE_FREE) begin
                first_page = 64'(addr) / PAGE_BYTES;
                stop_page  = first_page + need;
                for (int i = 0; i < PAGE_COUNT; i++) begin
                    abs_page = 64'(base_page) + 64'(i);
                    if (abs_page >= first_page && abs_page < stop_page)
                        page_used[i] = 1'b0;
                end
            end else if (bytes == 0) begin
                ans.status = STATUS_ZERO;
            end else if (need > PAGE_COUNT) begin
                ans.status = STATUS_NOFIT;
            end else begin
                ans.status = STATUS_NOFIT;
                // first fit: lowest run of free pages long enough
                for (int i = 0; i < PAGE_COUNT && ans.status == STATUS_NOFIT; i++) begin
                    if (page_used[i]) begin
                        run = 0;
                    end else begin
                        if (run == 0)
                            run_start = i;
                        run++;
                        if (run == need) begin
                            for (int j = run_start; j <= i; j++)
                                page_used[j] = 1'b1;
                            byte_addr   = (64'(base_page) + 64'(run_start)) * PAGE_BYTES;
                            ans.address = byte_addr[ADDR_W-1:0];
                            ans.status  = STATUS_DONE;
                        end
                    end
                end
            end
            due_answers.push_back(ans);
            return ans;
        endfunction

        function void check_result(logic [ADDR_W-1:0] addr, logic [1:0] status);
            page_answer_t want;
            if (due_answers.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result word: address %h status %0d",
                             $time, addr, status);
                return;
            end
            want = due_answers.pop_front();
            checked++;
            if (addr !== want.address) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: result_address expected %h actual %h",
                             $time, want.address, addr);
            end
            if (status !== want.status) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BASE_W-1:0]   cfg_base_page;
    logic                s_valid;
    logic                s_ready;
    logic                s_mode;
    logic [ADDR_W-1:0]   s_request_bytes;
    logic [ADDR_W-1:0]   s_address;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ADDR_W-1:0]   m_result_address;
    logic [1:0]          m_status;

    page_occupancy_board board = new();
    held_region_t        held_regions[$];
    logic                steady;
    logic                hold_req;
    int                  cycle_count = 0;
    int                  n_placed = 0;
    int                  n_nofit = 0;
    int                  n_zero = 0;
    int                  n_free = 0;
    int                  n_bases = 0;

    bitmap_contiguous_page_allocator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_base_page    (cfg_base_page),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_request_bytes  (s_request_bytes),
        .s_address        (s_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_address (m_result_address),
        .m_status         (m_status)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check every accepted word, then pick ready for the next cycle
    int  hold_left  = 0;
    bit  hold_taken = 1'b0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_result_address, m_status);
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] bytes,
                                input logic [ADDR_W-1:0] addr);
        page_answer_t ans;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_request_bytes <= bytes;
        s_address       <= addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        ans = board.predict_request(mode, bytes, addr);
        if (mode == MODE_FREE)
            n_free++;
        else if (ans.status == STATUS_ZERO)
            n_zero++;
        else if (ans.status == STATUS_NOFIT)
            n_nofit++;
        else begin
            n_placed++;
            held_regions.push_back('{ans.address, bytes});
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.due_answers.size() != 0)
            @(posedge aclk);
    endtask

    // Only while idle; the map survives a base change, the held list does not
    task automatic write_base(input logic [BASE_W-1:0] value);
        cfg_valid     <= 1'b1;
        cfg_base_page <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        board.base_page = value;
        held_regions.delete();
        n_bases++;
    endtask

    task automatic run_phase(input int n_items, input bit with_hold);
        int                pick;
        int                idx;
        logic [63:0]       pool_start;
        logic [ADDR_W-1:0] bytes;
        logic [ADDR_W-1:0] addr;
        held_region_t      region;
        pool_start = 64'(board.base_page) * PAGE_BYTES;
        for (int k = 0; k < n_items; k++) begin
            if (with_hold && k == 30)
                hold_req <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 45) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    bytes = $urandom_range(1, 8 * PAGE_BYTES);
                else if (pick < 97)
                    bytes = $urandom_range(1, 256) * PAGE_BYTES - $urandom_range(0, 100);
                else
                    bytes = $urandom_range(900, PAGE_COUNT) * PAGE_BYTES;
                send_request(MODE_ALLOC, bytes, $urandom());
            end else if (pick < 80 && held_regions.size() > 0) begin
                idx    = $urandom_range(held_regions.size() - 1);
                region = held_regions[idx];
                held_regions.delete(idx);
                addr   = region.address;
                bytes  = region.bytes;
                case ($urandom_range(3))
                    0: addr  = addr + $urandom_range(1, PAGE_BYTES - 1);
                    1: bytes = $urandom_range(1, bytes);
                    default: ;
                endcase
                send_request(MODE_FREE, bytes, addr);
            end else begin
                case ($urandom_range(5))
                    0: send_request(MODE_ALLOC, '0, $urandom());
                    1: send_request(MODE_FREE, '0, $urandom());
                    2: send_request(MODE_ALLOC, $urandom(), $urandom());
                    3: send_request(MODE_FREE, $urandom(), $urandom());
                    4: begin
                        send_request(MODE_FREE, '1,
                                     ADDR_W'(pool_start) + $urandom_range(0, PAGE_BYTES - 1));
                        held_regions.delete();
                    end
                    default: begin
                        // region starting outside the pool, below it where there is room, else above its end
                        if (board.base_page != 0)
                            addr = $urandom_range(0, ADDR_W'(pool_start) - 1);
                        else
                            addr = ADDR_W'(pool_start + PAGE_COUNT * PAGE_BYTES)
                                   + $urandom_range(0, 16 * PAGE_BYTES);
                        send_request(MODE_FREE, $urandom_range(1, 4 * PAGE_BYTES), addr);
                    end
                endcase
            end
        end
        wait_idle();
    endtask

    initial begin
        aresetn         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_base_page   <= '0;
        s_valid         <= 1'b0;
        s_mode          <= MODE_ALLOC;
        s_request_bytes <= '0;
        s_address       <= '0;
        steady          <= 1'b0;
        hold_req        <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_base('0);
        send_request(MODE_ALLOC, 32'd0, 32'd0);
        send_request(MODE_ALLOC, 32'd1, '1);
        send_request(MODE_ALLOC, PAGE_BYTES, 32'd0);
        send_request(MODE_ALLOC, PAGE_BYTES + 1, 32'd0);
        send_request(MODE_ALLOC, '1, 32'd0);
        send_request(MODE_ALLOC, PAGE_COUNT * PAGE_BYTES + 1, 32'd0);
        send_request(MODE_ALLOC, PAGE_COUNT * PAGE_BYTES, 32'd0);
        send_request(MODE_FREE, 32'd0, 32'd0);
        // misaligned start still frees the whole page it falls in
        send_request(MODE_FREE, 32'd1, PAGE_BYTES + 123);
        send_request(MODE_FREE, 2 * PAGE_BYTES, 200 * PAGE_BYTES);
        send_request(MODE_ALLOC, PAGE_BYTES, 32'd0);
        send_request(MODE_FREE, '1, '1);
        send_request(MODE_ALLOC, 3 * PAGE_BYTES, 32'd0);
        send_request(MODE_FREE, '1, 32'd0);
        send_request(MODE_ALLOC, PAGE_COUNT * PAGE_BYTES, 32'd0);
        send_request(MODE_ALLOC, 32'd1, 32'd0);
        send_request(MODE_FREE, (PAGE_COUNT - 4) * PAGE_BYTES, 2 * PAGE_BYTES);
        send_request(MODE_ALLOC, (PAGE_COUNT - 4) * PAGE_BYTES, 32'd0);
        send_request(MODE_FREE, PAGE_COUNT * PAGE_BYTES, 32'd0);
        wait_idle();

        write_base(BASE_W'(1047552));
        run_phase(PHASE_ITEMS, 1'b0);

        write_base(BASE_W'(3));
        steady <= 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);
        steady <= 1'b0;

        write_base(BASE_W'($urandom_range(1, 1047551)));
        run_phase(PHASE_ITEMS, 1'b1);

        write_base('0);
        run_phase(PHASE_ITEMS, 1'b0);

        repeat (100) @(posedge aclk);
        $display("Ran %0d placements, %0d no-fit, %0d zero-size and %0d frees over %0d bases",
                 n_placed, n_nofit, n_zero, n_free, n_bases);
        $display("%0d result words checked, %0d errors", board.checked, board.errors);
        if (board.errors == 0 && board.due_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
